>>> hdl/its_pkg.sv
// Shared widths, register codes and table entry type of the interval timer stats table.
`default_nettype none
package its_pkg;

  localparam int SLOT_COUNT       = 64;
  localparam int SLOT_BITS        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TIME_BITS        = 48;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
  localparam int PROD_BITS        = WEIGHT_BITS + TIME_BITS;
  localparam int COUNT_BITS       = 31;
  localparam int TOTAL_BITS       = 63;
  localparam int MIN_BITS         = 50;
  localparam int MAX_BITS         = 51;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET =
    WEIGHT_BITS'(((64'd1 << WEIGHT_FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic [MIN_BITS-1:0]        NONE_MIN = MIN_BITS'(64'd1000000000000000);
  localparam logic signed [MAX_BITS-1:0] NONE_MAX = MAX_BITS'(-64'sd1000000000000000);

  // configuration register indexes
  localparam logic REG_ENABLE     = 1'b0;
  localparam logic REG_EMA_WEIGHT = 1'b1;

  typedef struct packed {
    logic                        running;
    logic [TIME_BITS-1:0]        start_time;
    logic [COUNT_BITS-1:0]       count;
    logic [TOTAL_BITS-1:0]       total;
    logic [MIN_BITS-1:0]         min_time;
    logic signed [MAX_BITS-1:0]  max_time;
    logic [TIME_BITS-1:0]        ema;
  } its_entry_t;

  localparam int ENTRY_BITS = $bits(its_entry_t);

  localparam its_entry_t ENTRY_RESET = '{
    running:    1'b0,
    start_time: '0,
    count:      '0,
    total:      '0,
    min_time:   NONE_MIN,
    max_time:   NONE_MAX,
    ema:        '0
  };

endpackage
`default_nettype wire

>>> hdl/its_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module its_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int ADDR_BITS = 6
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/its_calc.sv
// Two-stage update datapath: interval, statistics and EMA products, then EMA sum.
`default_nettype none
module its_calc (
  input  wire logic                           clk,
  input  wire logic                           load_a,
  input  wire logic                           load_b,
  input  wire its_pkg::its_entry_t            entry_in,
  input  wire logic [its_pkg::TIME_BITS-1:0]  now,
  input  wire logic [its_pkg::WEIGHT_BITS-1:0] weight,
  output its_pkg::its_entry_t                 entry_out,
  output logic [its_pkg::TIME_BITS-1:0]       value,
  output logic                                was_stop
);
  import its_pkg::*;

  its_entry_t             ent_a;
  logic [TIME_BITS-1:0]   dt_a;
  logic [WEIGHT_BITS-1:0] w_a;

  its_entry_t                 ent_b;
  logic [TIME_BITS-1:0]       dt_b;
  logic [PROD_BITS-1:0]       prod_old_b;
  logic [PROD_BITS-1:0]       prod_new_b;
  logic [COUNT_BITS-1:0]      count_b;
  logic [TOTAL_BITS-1:0]      total_b;
  logic [MIN_BITS-1:0]        min_b;
  logic signed [MAX_BITS-1:0] max_b;

  logic [TOTAL_BITS:0]        tsum;
  logic signed [MAX_BITS-1:0] dt_signed;
  logic [PROD_BITS:0]         ema_sum;
  logic [TIME_BITS-1:0]       ema_new;

  always_ff @(posedge clk) begin
    if (load_a) begin
      ent_a <= entry_in;
      dt_a  <= now - entry_in.start_time;
      w_a   <= (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    end
  end

  assign tsum      = {1'b0, ent_a.total} + (TOTAL_BITS + 1)'(dt_a);
  assign dt_signed = MAX_BITS'(dt_a);

  always_ff @(posedge clk) begin
    if (load_b) begin
      ent_b      <= ent_a;
      dt_b       <= dt_a;
      prod_old_b <= PROD_BITS'(WEIGHT_ONE - w_a) * PROD_BITS'(ent_a.ema);
      prod_new_b <= PROD_BITS'(w_a) * PROD_BITS'(dt_a);
      count_b    <= (&ent_a.count) ? ent_a.count : ent_a.count + 1'b1;
      total_b    <= tsum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : tsum[TOTAL_BITS-1:0];
      min_b      <= (MIN_BITS'(dt_a) < ent_a.min_time) ? MIN_BITS'(dt_a) : ent_a.min_time;
      max_b      <= (dt_signed > ent_a.max_time) ? dt_signed : ent_a.max_time;
    end
  end

  assign ema_sum = {1'b0, prod_old_b} + {1'b0, prod_new_b};
  assign ema_new = ema_sum[WEIGHT_FRAC_BITS +: TIME_BITS];

  always_comb begin
    entry_out = ent_b;
    if (ent_b.running) begin
      entry_out.running  = 1'b0;
      entry_out.count    = count_b;
      entry_out.total    = total_b;
      entry_out.min_time = min_b;
      entry_out.max_time = max_b;
      entry_out.ema      = ema_new;
      value              = dt_b;
    end else begin
      entry_out.running    = 1'b1;
      entry_out.start_time = now;
      value                = now;
    end
  end

  assign was_stop = ent_b.running;

endmodule
`default_nettype wire

>>> hdl/interval_timer_stats_table.sv
// Top level of the interval timer stats table: control, config registers, table RAM.
//
// Usage: an event item (slot, timestamp) is taken at a clock edge where start
// is high and busy is low. Each event toggles its slot between started and
// stopped. A start returns the timestamp; a stop returns the elapsed time
// modulo 2^48 and updates count and total (saturating), min, max and EMA.
// Every item gives one result: done is high for one cycle with value,
// was_stop and the slot's statistics as they stand after the event.
// Steps: RAM read at the accepting edge, then interval, then statistics and EMA
// products, then EMA sum and write-back; busy drops with done, so a new item can
// be taken in the done cycle. With enable low the result is all zeros,
// done rises at the accepting edge, and the next item may follow right away.
// Config: wr_en/wr_index/wr_data write enable (0) or ema_weight (1); the user
// must write only while busy is low, which the block does not enforce; no read-back.
// Reset: enable = 1, ema_weight = 655; a per-slot valid bit makes every
// slot read as empty (min 10^15, max -10^15), so no clearing pass is needed.
// The receiver cannot stall: results must be taken in the done cycle.
`default_nettype none
module interval_timer_stats_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [5:0]                          slot,
  input  wire logic [47:0]                         timestamp,
  input  wire logic                                wr_en,
  input  wire logic                                wr_index,
  input  wire logic [its_pkg::WEIGHT_BITS-1:0]     wr_data,
  output logic                                     done,
  output logic [47:0]                              value,
  output logic                                     was_stop,
  output logic [its_pkg::COUNT_BITS-1:0]           call_count,
  output logic [its_pkg::TOTAL_BITS-1:0]           total_time,
  output logic [its_pkg::MIN_BITS-1:0]             min_time,
  output logic signed [its_pkg::MAX_BITS-1:0]      max_time,
  output logic [47:0]                              ema_time
);
  import its_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]             state;
  logic                   enable;
  logic [WEIGHT_BITS-1:0] ema_weight;
  logic [SLOT_COUNT-1:0]  valid;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [TIME_BITS-1:0]   now_q;

  logic                   accept;
  logic                   slot_ok;
  logic [ENTRY_BITS-1:0]  rd_data;
  its_entry_t             rd_entry;
  its_entry_t             new_entry;
  logic [TIME_BITS-1:0]   calc_value;
  logic                   calc_stop;
  logic                   wr_mem;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign slot_ok = ({1'b0, slot} < 7'(SLOT_COUNT));
  assign wr_mem  = (state == ST_UPD);

  its_ram #(
    .WIDTH     (ENTRY_BITS),
    .DEPTH     (SLOT_COUNT),
    .ADDR_BITS (SLOT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_mem),
    .waddr (slot_q),
    .wdata (ENTRY_BITS'(new_entry)),
    .re    (accept),
    .raddr (SLOT_BITS'(slot)),
    .rdata (rd_data)
  );

  assign rd_entry = valid[slot_q] ? its_entry_t'(rd_data) : ENTRY_RESET;

  its_calc u_calc (
    .clk       (clk),
    .load_a    (state == ST_READ),
    .load_b    (state == ST_MUL),
    .entry_in  (rd_entry),
    .now       (now_q),
    .weight    (ema_weight),
    .entry_out (new_entry),
    .value     (calc_value),
    .was_stop  (calc_stop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      ema_weight <= WEIGHT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLE:     enable     <= wr_data[0];
        REG_EMA_WEIGHT: ema_weight <= wr_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      valid <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (enable && slot_ok) begin
              state <= ST_READ;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_READ: state <= ST_MUL;
        ST_MUL:  state <= ST_UPD;
        ST_UPD: begin
          state         <= ST_IDLE;
          done          <= 1'b1;
          valid[slot_q] <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q <= SLOT_BITS'(slot);
      now_q  <= timestamp[TIME_BITS-1:0];
    end
    if (accept && !(enable && slot_ok)) begin
      value      <= '0;
      was_stop   <= 1'b0;
      call_count <= '0;
      total_time <= '0;
      min_time   <= '0;
      max_time   <= '0;
      ema_time   <= '0;
    end else if (state == ST_UPD) begin
      value      <= 48'(calc_value);
      was_stop   <= calc_stop;
      call_count <= new_entry.count;
      total_time <= new_entry.total;
      min_time   <= new_entry.min_time;
      max_time   <= new_entry.max_time;
      ema_time   <= 48'(new_entry.ema);
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while an item is in flight");

  a_upd_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |=> done)
    else $error("write-back without result");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted item dropped");

  a_stop_bounds: assert property (@(posedge clk) disable iff (rst)
    (done && was_stop) |->
      ((min_time <= MIN_BITS'(value)) && (max_time >= $signed(MAX_BITS'(value)))))
    else $error("interval outside min/max after stop");

endmodule
`default_nettype wire
